// File: rtl/core/idba_pkg.sv
// package: shared constants, types and codes for the interval admission block
`default_nettype none
package idba_pkg;

    localparam int BOOKED_DEPTH = 1024;
    localparam int DOUBLE_DEPTH = 1024;

    localparam int TIME_W = 30;
    localparam int SPAN_W = 2 * TIME_W;
    localparam int STAT_W = 2;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 8;

    localparam int BK_AW = $clog2(BOOKED_DEPTH);
    localparam int DB_AW = $clog2(DOUBLE_DEPTH);
    localparam int BK_CW = $clog2(BOOKED_DEPTH + 1);
    localparam int DB_CW = $clog2(DOUBLE_DEPTH + 1);
    localparam int IDX_W = (BK_CW > DB_CW) ? BK_CW : DB_CW;

    localparam logic [STAT_W-1:0] ST_ACCEPT = 2'd0;
    localparam logic [STAT_W-1:0] ST_TRIPLE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    localparam logic [1:0] PH_DBL  = 2'd0;
    localparam logic [1:0] PH_CNT  = 2'd1;
    localparam logic [1:0] PH_FILL = 2'd2;

    typedef struct packed {
        logic       load;
        logic       clr_idx;
        logic       issue;
        logic [1:0] phase;
        logic       chk;
        logic       commit;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic issue_done;
        logic pipe_empty;
        logic triple;
        logic full;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// File: rtl/core/idba_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module idba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire [WIDTH-1:0]          wr_data,
    input  wire                      rd_en,
    input  wire [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/idba_ctrl.sv
// controller: sequences the table scans, the fill pass and the result word
`default_nettype none
module idba_ctrl (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            s_tvalid,
    output logic           s_tready,
    input  wire idba_pkg::stat_t stat,
    output idba_pkg::cmd_t  cmd
);
    import idba_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN_D = 3'd1;
    localparam logic [2:0] S_SCAN_B = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;
    localparam logic [2:0] S_RESP   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        cmd.phase = PH_DBL;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    state_next = S_SCAN_D;
                end
            end
            S_SCAN_D: begin
                cmd.phase = PH_DBL;
                cmd.issue = !stat.issue_done;
                if (stat.issue_done && stat.pipe_empty) begin
                    if (stat.triple) begin
                        state_next = S_RESP;
                    end else begin
                        cmd.clr_idx = 1'b1;
                        state_next = S_SCAN_B;
                    end
                end
            end
            S_SCAN_B: begin
                cmd.phase = PH_CNT;
                cmd.issue = !stat.issue_done;
                if (stat.issue_done && stat.pipe_empty) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.chk = 1'b1;
                if (stat.full) begin
                    state_next = S_RESP;
                end else begin
                    cmd.clr_idx = 1'b1;
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                cmd.phase = PH_FILL;
                cmd.issue = !stat.issue_done;
                if (stat.issue_done && stat.pipe_empty) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/idba_dp.sv
// datapath: both interval tables, counts, overlap compare and result register
`default_nettype none
module idba_dp (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire [idba_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [idba_pkg::M_DATA_W-1:0]      m_tdata,
    input  wire idba_pkg::cmd_t                cmd,
    output idba_pkg::stat_t                    stat
);
    import idba_pkg::*;

    logic [TIME_W-1:0] s_reg, e_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              rd_vld_reg;
    logic [1:0]        rd_ph_reg;
    logic [BK_CW-1:0]  bk_cnt_reg;
    logic [DB_CW-1:0]  db_cnt_reg;
    logic [BK_CW-1:0]  hits_reg;
    logic              triple_reg;
    logic              full_reg;
    logic              m_tvalid_reg;
    logic [STAT_W-1:0] m_stat_reg;

    logic [SPAN_W-1:0] bk_rd_data, db_rd_data, ent;
    logic [TIME_W-1:0] ent_lo, ent_hi, ov_lo, ov_hi;
    logic              ov;
    logic [IDX_W-1:0]  limit;
    logic              bk_rd_en, db_rd_en, bk_wr_en, db_wr_en;
    logic [IDX_W:0]    hits_x, free_x;
    logic              full;

    // table read side
    assign limit    = (cmd.phase == PH_DBL) ? IDX_W'(db_cnt_reg) : IDX_W'(bk_cnt_reg);
    assign db_rd_en = cmd.issue && (cmd.phase == PH_DBL);
    assign bk_rd_en = cmd.issue && (cmd.phase != PH_DBL);

    assign ent    = (rd_ph_reg == PH_DBL) ? db_rd_data : bk_rd_data;
    assign ent_lo = ent[TIME_W-1:0];
    assign ent_hi = ent[SPAN_W-1:TIME_W];
    assign ov_lo  = (s_reg > ent_lo) ? s_reg : ent_lo;
    assign ov_hi  = (e_reg < ent_hi) ? e_reg : ent_hi;
    assign ov     = ov_lo < ov_hi;

    assign db_wr_en = rd_vld_reg && (rd_ph_reg == PH_FILL) && ov;
    assign bk_wr_en = cmd.commit;

    // room check
    assign hits_x = (IDX_W+1)'(hits_reg);
    assign free_x = (IDX_W+1)'(DOUBLE_DEPTH) - (IDX_W+1)'(db_cnt_reg);
    assign full   = (bk_cnt_reg == BK_CW'(BOOKED_DEPTH)) || (hits_x > free_x);

    idba_ram #(.WIDTH(SPAN_W), .DEPTH(BOOKED_DEPTH)) u_bk_ram (
        .aclk    (aclk),
        .wr_en   (bk_wr_en),
        .wr_addr (bk_cnt_reg[BK_AW-1:0]),
        .wr_data ({e_reg, s_reg}),
        .rd_en   (bk_rd_en),
        .rd_addr (idx_reg[BK_AW-1:0]),
        .rd_data (bk_rd_data)
    );

    idba_ram #(.WIDTH(SPAN_W), .DEPTH(DOUBLE_DEPTH)) u_db_ram (
        .aclk    (aclk),
        .wr_en   (db_wr_en),
        .wr_addr (db_cnt_reg[DB_AW-1:0]),
        .wr_data ({ov_hi, ov_lo}),
        .rd_en   (db_rd_en),
        .rd_addr (idx_reg[DB_AW-1:0]),
        .rd_data (db_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            s_reg <= s_tdata[TIME_W-1:0];
            e_reg <= s_tdata[SPAN_W-1:TIME_W];
        end
        if (cmd.out_load) begin
            m_stat_reg <= triple_reg ? ST_TRIPLE : (full_reg ? ST_FULL : ST_ACCEPT);
        end
        rd_ph_reg <= cmd.phase;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            bk_cnt_reg   <= '0;
            db_cnt_reg   <= '0;
            hits_reg     <= '0;
            triple_reg   <= 1'b0;
            full_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.issue;
            if (cmd.load || cmd.clr_idx) begin
                idx_reg <= '0;
            end else if (cmd.issue) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.load) begin
                hits_reg   <= '0;
                triple_reg <= 1'b0;
                full_reg   <= 1'b0;
            end else begin
                if (rd_vld_reg && ov && (rd_ph_reg == PH_DBL)) begin
                    triple_reg <= 1'b1;
                end
                if (rd_vld_reg && ov && (rd_ph_reg == PH_CNT)) begin
                    hits_reg <= hits_reg + BK_CW'(1);
                end
                if (cmd.chk) begin
                    full_reg <= full;
                end
            end
            if (db_wr_en) begin
                db_cnt_reg <= db_cnt_reg + DB_CW'(1);
            end
            if (bk_wr_en) begin
                bk_cnt_reg <= bk_cnt_reg + BK_CW'(1);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign stat.issue_done = (idx_reg == limit);
    assign stat.pipe_empty = !rd_vld_reg;
    assign stat.triple     = triple_reg;
    assign stat.full       = full;
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W-STAT_W){1'b0}}, m_stat_reg};

endmodule
`default_nettype wire

// File: rtl/core/interval_double_booking_admit.sv
// top level: interval admission against booked and double-booked tables
//
// channel | dir | tdata fields (low bit up)                  | word meaning
// s_      | in  | start_time[29:0], end_time[59:30], pad 0   | one interval request
// m_      | out | status[1:0], pad 0                         | one answer per request
//
// an accepted request goes through a double table scan, a booked table count,
// a room check, a fill scan of the booked table and a commit; each table scan
// reads one entry per cycle through the ram port; a request hitting a double
// entry answers after the double scan, one rejected for lack of room after the
// booked count; reset clears both counts; no ram clearing pass is needed
// the answer waits in an output register; the next request is taken meanwhile
`default_nettype none
module interval_double_booking_admit (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire [idba_pkg::S_DATA_W-1:0]    s_tdata,   // start_time, end_time
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [idba_pkg::M_DATA_W-1:0]   m_tdata    // status
);
    import idba_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    idba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    idba_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
`default_nettype wire

// File: rtl/core/idba_chk.sv
// checker: port-level properties of the interval admission block, with bind
`default_nettype none
module idba_chk (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire [idba_pkg::S_DATA_W-1:0]   s_tdata,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [idba_pkg::M_DATA_W-1:0]   m_tdata
);
    import idba_pkg::*;

    logic unused_in;
    assign unused_in = ^s_tdata;

    // stalled result word holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // status is a defined code with zero padding
    a_m_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_DATA_W-1:STAT_W] == '0) &&
                     (m_tdata[STAT_W-1:0] != 2'd3))
        else $error("undefined status code");

    // no result right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an accepted request keeps the input side busy next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accept");

    // a result is never produced in the cycle after a request arrives
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind interval_double_booking_admit idba_chk u_idba_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
